>>> rtl/chcm_pkg.sv
`default_nettype none
package chcm_pkg;
  localparam int unsigned BucketsDefault = 1024;
  localparam int unsigned NodesDefault = 1024;
  localparam logic [31:0] MultXReset = 32'd73856093;
  localparam logic [31:0] MultYReset = 32'd19349663;
  localparam logic [31:0] MultZReset = 32'd83492791;
  localparam logic [31:0] OffsetReset = 32'd0;

  localparam logic [1:0] RegMultX = 2'd0;
  localparam logic [1:0] RegMultY = 2'd1;
  localparam logic [1:0] RegMultZ = 2'd2;
  localparam logic [1:0] RegOffset = 2'd3;

  localparam logic CmdLookup = 1'b0;
  localparam logic CmdInsert = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_MOD,
    ST_HEAD,
    ST_HEAD_WAIT,
    ST_INSERT,
    ST_NODE,
    ST_NODE_WAIT,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

>>> rtl/coord_hash_chained_map_top.sv
`default_nettype none
// Spatial hash map from signed 3D coordinates to a 16-bit identifier. After reset the
// block sweeps the bucket head memory, one entry per cycle, and accepts no word
// meanwhile. Each word then runs through one shared 32x32 multiplier (three products
// accumulated into the weighted sum, then a spare step), the bucket index (a mask, or a
// compare and subtract loop over the magnitude for bucket counts that are not a power
// of two), the registered head memory read (ST_HEAD, then ST_HEAD_WAIT), and for a
// lookup one pass per chain node visited (registered node memory read, then key
// compare) plus a last node state that sees the end of the chain on a miss. Results
// wait in an output register, one word in flight at a time; a result that is not taken
// holds the block in its result state and the input stalls.
module coord_hash_chained_map_top
  import chcm_pkg::*;
#(
  parameter int unsigned BUCKETS = BucketsDefault,
  parameter int unsigned NODES = NodesDefault
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [111:96] ident_in
  input  wire [111:0] in_tdata,
  // cmd
  input  wire         in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // [0] found, [16:1] ident_out, [17] status, padded to 24 bits
  output logic [23:0] out_tdata,
  input  wire         cfg_we,
  input  wire [1:0]   cfg_index,
  input  wire [31:0]  cfg_wdata
);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int PW = $clog2(NODES + 1);
  localparam bit BPOW2 = (BUCKETS & (BUCKETS - 1)) == 0;
  localparam logic [32:0] BUCK33 = 33'(BUCKETS);

  logic [31:0] mult_x_r, mult_y_r, mult_z_r, offset_r;
  state_t state_r, state_nxt;
  logic cmd_r;
  logic [31:0] px_r, py_r, pz_r;
  logic [15:0] id_r;
  logic [1:0] step_r;
  logic [31:0] acc_r;
  logic [32:0] rem_r;
  logic [5:0] bit_r;
  logic [BW-1:0] bkt_r;
  logic [BW-1:0] clr_r;
  logic [PW-1:0] head_r, used_r, ptr_r;
  logic [PW-1:0] head_mem [BUCKETS];
  logic [PW-1:0] head_rd_r;
  logic [31:0] nkx [NODES];
  logic [31:0] nky [NODES];
  logic [31:0] nkz [NODES];
  logic [15:0] nid [NODES];
  logic [PW-1:0] nlk [NODES];
  logic [31:0] rx_r, ry_r, rz_r;
  logic [15:0] rid_r;
  logic [PW-1:0] rlk_r;
  logic found_r, status_r;
  logic [15:0] ident_r;
  logic [23:0] out_word_r;

  // shared multiplier
  logic [31:0] mul_a, mul_b, mul_p;
  always_comb begin
    unique case (step_r)
      2'd0: begin mul_a = px_r; mul_b = mult_x_r; end
      2'd1: begin mul_a = py_r; mul_b = mult_y_r; end
      default: begin mul_a = pz_r; mul_b = mult_z_r; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  logic [31:0] mag;
  assign mag = acc_r[31] ? (32'd0 - acc_r) : acc_r;
  logic [32:0] rem_sh;
  assign rem_sh = {rem_r[31:0], mag[5'(bit_r - 6'd1)]};

  logic key_eq;
  assign key_eq = (rx_r == px_r) && (ry_r == py_r) && (rz_r == pz_r);
  logic ptr_ok;
  assign ptr_ok = (ptr_r != '0) && ({1'b0, ptr_r} <= (PW+1)'(NODES));
  logic [NW-1:0] ptr_idx;
  assign ptr_idx = NW'(ptr_r - PW'(1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == BW'(BUCKETS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: if (in_tvalid) state_nxt = ST_MUL;
      ST_MUL: if (step_r == 2'd3) state_nxt = ST_MOD;
      ST_MOD: if (BPOW2 || bit_r == 6'd0) state_nxt = ST_HEAD;
      ST_HEAD: state_nxt = ST_HEAD_WAIT;
      ST_HEAD_WAIT: state_nxt = cmd_r ? ST_INSERT : ST_NODE;
      ST_INSERT: state_nxt = ST_DONE;
      ST_NODE: state_nxt = ptr_ok ? ST_NODE_WAIT : ST_DONE;
      ST_NODE_WAIT: state_nxt = key_eq ? ST_DONE : ST_NODE;
      ST_DONE: if (!out_tvalid || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_x_r <= MultXReset; mult_y_r <= MultYReset;
      mult_z_r <= MultZReset; offset_r <= OffsetReset;
      state_r <= ST_CLEAR; clr_r <= '0; used_r <= '0; out_tvalid <= 1'b0;
      step_r <= '0; bit_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          RegMultX: mult_x_r <= cfg_wdata;
          RegMultY: mult_y_r <= cfg_wdata;
          RegMultZ: mult_z_r <= cfg_wdata;
          RegOffset: offset_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      unique case (state_r)
        ST_CLEAR: clr_r <= clr_r + BW'(1);
        ST_IDLE: begin
          step_r <= '0;
          bit_r <= 6'd32;
        end
        ST_MUL: step_r <= step_r + 2'd1;
        ST_MOD: if (!BPOW2) bit_r <= bit_r - 6'd1;
        ST_INSERT: if ({1'b0, used_r} < (PW+1)'(NODES)) used_r <= used_r + PW'(1);
        ST_DONE: if (!out_tvalid || out_tready) out_tvalid <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        cmd_r <= in_tuser;
        px_r <= in_tdata[31:0]; py_r <= in_tdata[63:32];
        pz_r <= in_tdata[95:64]; id_r <= in_tdata[111:96];
        acc_r <= offset_r; rem_r <= '0;
        found_r <= 1'b0; ident_r <= '0; status_r <= 1'b0;
      end
      ST_MUL: if (step_r != 2'd3) acc_r <= acc_r + mul_p;
      ST_MOD: begin
        if (BPOW2) begin
          bkt_r <= BW'(mag & 32'(BUCKETS - 1));
        end else if (bit_r != 6'd0) begin
          rem_r <= (rem_sh >= BUCK33) ? rem_sh - BUCK33 : rem_sh;
        end else begin
          bkt_r <= BW'(rem_r);
        end
      end
      ST_HEAD: head_rd_r <= head_mem[bkt_r];
      ST_HEAD_WAIT: begin head_r <= head_rd_r; ptr_r <= head_rd_r; end
      ST_INSERT: if ({1'b0, used_r} >= (PW+1)'(NODES)) status_r <= 1'b1;
      ST_NODE: begin
        rx_r <= nkx[ptr_idx]; ry_r <= nky[ptr_idx]; rz_r <= nkz[ptr_idx];
        rid_r <= nid[ptr_idx]; rlk_r <= nlk[ptr_idx];
      end
      ST_NODE_WAIT: begin
        if (key_eq) begin found_r <= 1'b1; ident_r <= rid_r; end
        ptr_r <= rlk_r;
      end
      // result word is held here while the next word is taken in
      ST_DONE: if (!out_tvalid || out_tready) out_word_r <= {6'd0, status_r, ident_r, found_r};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) head_mem[clr_r] <= '0;
    else if (state_r == ST_INSERT && {1'b0, used_r} < (PW+1)'(NODES))
      head_mem[bkt_r] <= used_r + PW'(1);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_INSERT && {1'b0, used_r} < (PW+1)'(NODES)) begin
      nkx[NW'(used_r)] <= px_r; nky[NW'(used_r)] <= py_r; nkz[NW'(used_r)] <= pz_r;
      nid[NW'(used_r)] <= id_r; nlk[NW'(used_r)] <= head_r;
    end
  end

  assign out_tdata = out_word_r;
endmodule
`default_nettype wire

>>> tb/sv/coord_hash_chained_map_top_tb.sv
`default_nettype none
module coord_hash_chained_map_top_tb;
  import chcm_pkg::*;

  localparam int unsigned NB = BucketsDefault;
  localparam int unsigned NN = NodesDefault;

  typedef struct packed {
    logic        cmd;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [15:0] ident;
  } map_op_t;

  typedef struct packed {
    logic        found;
    logic [15:0] ident;
    logic        status;
  } map_resp_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [23:0]  out_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_wdata;

  coord_hash_chained_map_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // shadow of the table
  logic [31:0] hmul_x, hmul_y, hmul_z, hoff;
  logic [10:0] head_tbl [NB];
  logic [31:0] key_x [NN];
  logic [31:0] key_y [NN];
  logic [31:0] key_z [NN];
  logic [15:0] key_id [NN];
  logic [10:0] key_link [NN];
  int unsigned nodes_used;

  map_op_t   pending_ops[$];
  map_resp_t expected_resps[$];
  int unsigned errors;
  bit        drain_hold;
  bit        hold_out;
  bit        in_acc;
  int unsigned idle_cycles;

  // known keys for lookups that hit
  logic [95:0] used_keys[$];

  function automatic int unsigned bucket_index(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    logic [31:0] s;
    logic [31:0] m;
    s = x * hmul_x + y * hmul_y + z * hmul_z + hoff;
    m = s[31] ? (32'd0 - s) : s;
    return m % NB;
  endfunction

  function automatic map_resp_t map_apply(map_op_t op);
    map_resp_t r;
    int unsigned b;
    int unsigned p;
    int unsigned n;
    int unsigned steps;
    r = '0;
    b = bucket_index(op.px, op.py, op.pz);
    if (op.cmd == CmdInsert) begin
      if (nodes_used >= NN) begin
        r.status = 1'b1;
      end else begin
        n = nodes_used;
        key_x[n] = op.px;
        key_y[n] = op.py;
        key_z[n] = op.pz;
        key_id[n] = op.ident;
        key_link[n] = head_tbl[b];
        head_tbl[b] = 11'(n + 1);
        nodes_used = n + 1;
      end
    end else begin
      p = head_tbl[b];
      steps = 0;
      while (p != 0 && steps < NN) begin
        n = p - 1;
        if (key_x[n] == op.px && key_y[n] == op.py && key_z[n] == op.pz) begin
          r.found = 1'b1;
          r.ident = key_id[n];
          break;
        end
        p = key_link[n];
        steps++;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 8)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_op(logic cmd, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                         logic [15:0] id);
    map_op_t op;
    op.cmd = cmd;
    op.px = x;
    op.py = y;
    op.pz = z;
    op.ident = id;
    pending_ops.push_back(op);
    if (cmd == CmdInsert) used_keys.push_back({x, y, z});
  endtask

  task automatic wait_empty();
    while (pending_ops.size() != 0 || expected_resps.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegMultX: hmul_x = val;
      RegMultY: hmul_y = val;
      RegMultZ: hmul_z = val;
      default:  hoff = val;
    endcase
  endtask

  task automatic random_ops(int unsigned count, int unsigned ins_pct);
    logic [95:0] k;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < ins_pct) begin
        if (used_keys.size() != 0 && $urandom_range(0, 3) == 0) begin
          k = used_keys[$urandom_range(0, used_keys.size() - 1)];
          push_op(CmdInsert, k[95:64], k[63:32], k[31:0], 16'($urandom));
        end else begin
          push_op(CmdInsert, rand_coord(), rand_coord(), rand_coord(), 16'($urandom));
        end
      end else if (used_keys.size() != 0 && $urandom_range(0, 2) != 0) begin
        k = used_keys[$urandom_range(0, used_keys.size() - 1)];
        push_op(CmdLookup, k[95:64], k[63:32], k[31:0], 16'($urandom));
      end else begin
        push_op(CmdLookup, rand_coord(), rand_coord(), rand_coord(), 16'($urandom));
      end
    end
  endtask

  // sender: bursts and gaps
  int unsigned burst_left;
  int unsigned gap_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_acc) begin
      // hold the offered word until it is taken
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      in_tvalid <= 1'b0;
    end else if (pending_ops.size() != 0 && !drain_hold) begin
      in_tvalid <= 1'b1;
      in_tuser <= pending_ops[0].cmd;
      in_tdata <= {pending_ops[0].ident, pending_ops[0].pz, pending_ops[0].py,
                   pending_ops[0].px};
      if (burst_left == 0) begin
        burst_left <= $urandom_range(1, 20);
        if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 30);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // receiver stalls on its own pattern
  int unsigned stall_phase;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (hold_out) out_tready <= 1'b0;
    else if (stall_phase[9:8] == 2'd0) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  // input side acceptance feeds the predictor
  always @(posedge clk) begin
    in_acc <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      expected_resps.push_back(map_apply(pending_ops.pop_front()));
    end
  end

  map_resp_t got;
  map_resp_t want;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.found = out_tdata[0];
      got.ident = out_tdata[16:1];
      got.status = out_tdata[17];
      if (expected_resps.size() == 0) begin
        $error("unexpected word %h", out_tdata);
        errors++;
      end else begin
        want = expected_resps.pop_front();
        if (got.found !== want.found) begin
          $error("found: expected %0d got %0d", want.found, got.found);
          errors++;
        end
        if (got.ident !== want.ident) begin
          $error("ident_out: expected %0d got %0d", want.ident, got.ident);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d got %0d", want.status, got.status);
          errors++;
        end
      end
    end
  end

  // watchdog; covers the head memory sweep after reset
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // long output hold-off while the sender keeps going
  initial begin
    hold_out = 1'b0;
    wait (nodes_used > 200);
    hold_out = 1'b1;
    repeat (400) @(posedge clk);
    hold_out = 1'b0;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = RegMultX;
    cfg_wdata = '0;
    errors = 0;
    nodes_used = 0;
    burst_left = 0;
    gap_left = 0;
    stall_phase = 0;
    drain_hold = 1'b0;
    in_acc = 1'b0;
    hmul_x = MultXReset;
    hmul_y = MultYReset;
    hmul_z = MultZReset;
    hoff = OffsetReset;
    for (int i = 0; i < NB; i++) head_tbl[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: misses on empty table, extremes, shadowing duplicates
    push_op(CmdLookup, 32'h0, 32'h0, 32'h0, 16'hffff);
    push_op(CmdInsert, 32'h0, 32'h0, 32'h0, 16'h0000);
    push_op(CmdLookup, 32'h0, 32'h0, 32'h0, 16'h0);
    push_op(CmdInsert, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hffff);
    push_op(CmdInsert, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h1234);
    push_op(CmdLookup, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0);
    push_op(CmdLookup, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h0);
    push_op(CmdInsert, 32'h0, 32'h0, 32'h0, 16'habcd);
    push_op(CmdLookup, 32'h0, 32'h0, 32'h0, 16'h0);
    push_op(CmdLookup, 32'h1, 32'h0, 32'h0, 16'h0);
    push_op(CmdInsert, 32'hffff_ffff, 32'h1, 32'hffff_fffe, 16'h5555);
    push_op(CmdLookup, 32'hffff_ffff, 32'h1, 32'hffff_fffe, 16'h0);
    wait_empty();

    // all-zero multipliers and a most-negative offset: every key in one bucket
    write_reg(RegMultX, 32'h0);
    write_reg(RegMultY, 32'h0);
    write_reg(RegMultZ, 32'h0);
    write_reg(RegOffset, 32'h8000_0000);
    random_ops(40, 50);
    wait_empty();

    write_reg(RegMultX, 32'h7fff_ffff);
    write_reg(RegMultY, 32'h8000_0000);
    write_reg(RegMultZ, 32'hffff_ffff);
    write_reg(RegOffset, 32'h7fff_ffff);
    random_ops(150, 40);
    // sender pauses until everything has come back
    wait_empty();

    write_reg(RegMultX, $urandom);
    write_reg(RegMultY, $urandom);
    write_reg(RegMultZ, $urandom);
    write_reg(RegOffset, $urandom);
    random_ops(250, 45);
    wait_empty();

    write_reg(RegMultX, MultXReset);
    write_reg(RegMultY, MultYReset);
    write_reg(RegMultZ, MultZReset);
    write_reg(RegOffset, 32'h0);
    // insert-heavy traffic with lookups; the node pool does not fill, so no insert is dropped
    random_ops(300, 75);
    wait_empty();

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
